// ----- rtl/gmp_pkg.sv -----
// ----------------------------------------------------------------------------
// gmp_pkg: shared types and constants for the grid path score unit
// Holds the cell beat layout, control structs and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package gmp_pkg;

    // Configuration register indexes (word index = byte address / 4).
    localparam int unsigned REG_GRID_SIDE = 0;

    // Width of the grid side register and of the APB data bus.
    localparam int unsigned SIDE_W  = 6;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 3;

    // Field widths.
    localparam int unsigned VAL_W   = 16;
    localparam int unsigned SCORE_W = 32;

    // Cell value that marks a blocked cell.
    localparam logic signed [VAL_W-1:0] BLOCKED_VALUE = -16'sd1;

    // Depth of the queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Position flags worked out by the front for each cell.
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_cell;
    } cell_tag_t;

    // One classified cell as it travels through the queue.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] cost_up;
        logic signed [VAL_W-1:0] cost_left;
        cell_tag_t               tag;
    } cell_t;

    // Status of the back part, seen by the top level.
    typedef struct packed {
        logic load;
        logic commit;
        logic last_commit;
    } back_status_t;

endpackage

`default_nettype wire

// ----- rtl/gmp_ram.sv -----
// ----------------------------------------------------------------------------
// gmp_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gmp_ram #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/gmp_front.sv -----
// ----------------------------------------------------------------------------
// gmp_front: cell intake and classification
// Tracks the raster position and tags each accepted cell with its place.
// ----------------------------------------------------------------------------
`default_nettype none

module gmp_front #(
    parameter int unsigned MAX_SIDE = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               restart,
    input  wire logic [$clog2(MAX_SIDE+1)-1:0]      side,
    input  wire logic                               cell_valid,
    input  wire logic signed [gmp_pkg::VAL_W-1:0]   cell_value,
    input  wire logic signed [gmp_pkg::VAL_W-1:0]   cost_from_above,
    input  wire logic signed [gmp_pkg::VAL_W-1:0]   cost_from_left,
    input  wire logic                               q_full,
    output logic                                    push,
    output gmp_pkg::cell_t                          cell_beat,
    output logic [$clog2(MAX_SIDE)-1:0]             col
);

    localparam int unsigned IW = $clog2(MAX_SIDE);
    localparam int unsigned SW = $clog2(MAX_SIDE + 1);

    logic [IW-1:0] row_reg;
    logic [IW-1:0] row_next;
    logic [IW-1:0] col_reg;
    logic [IW-1:0] col_next;
    logic          end_of_row;
    logic          end_of_grid;

    // A beat is taken whenever the queue has room.
    assign push = cell_valid && !q_full;

    // Position flags for the cell at the current raster position.
    assign end_of_row  = (SW'(col_reg) == side - SW'(1));
    assign end_of_grid = (SW'(row_reg) == side - SW'(1));

    always_comb
    begin
        cell_beat.value          = cell_value;
        cell_beat.cost_up        = cost_from_above;
        cell_beat.cost_left      = cost_from_left;
        cell_beat.tag.first_row  = (row_reg == '0);
        cell_beat.tag.first_col  = (col_reg == '0);
        cell_beat.tag.last_cell  = end_of_row && end_of_grid;
        col                      = col_reg;
    end

    // Raster position advance.
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (push)
        begin
            if (end_of_row)
            begin
                col_next = '0;
                row_next = end_of_grid ? '0 : row_reg + IW'(1);
            end
            else
            begin
                col_next = col_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gmp_queue.sv -----
// ----------------------------------------------------------------------------
// gmp_queue: short queue between the front and the back
// A small register queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module gmp_queue #(
    parameter int unsigned WIDTH = 56
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head_data,
    output logic                  not_empty,
    output logic                  full
);

    localparam int unsigned PW = $clog2(gmp_pkg::QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(gmp_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [gmp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign head_data = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(gmp_pkg::QUEUE_DEPTH));

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gmp_back.sv -----
// ----------------------------------------------------------------------------
// gmp_back: path score datapath
// Reads the row buffer, scores one cell a cycle unless stalled, holds results.
// ----------------------------------------------------------------------------
`default_nettype none

module gmp_back #(
    parameter int unsigned MAX_SIDE = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 q_not_empty,
    input  wire gmp_pkg::cell_t                       q_cell,
    input  wire logic [$clog2(MAX_SIDE)-1:0]          q_col,
    output gmp_pkg::back_status_t                     status,
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic signed [gmp_pkg::SCORE_W-1:0]        best_score,
    output logic                                      end_blocked
);

    localparam int unsigned IW = $clog2(MAX_SIDE);
    localparam int unsigned SC = gmp_pkg::SCORE_W;
    localparam int unsigned RW = SC + 1;

    // Stage register: the cell whose row-buffer read is in flight.
    logic                 s1_valid_reg;
    gmp_pkg::cell_t       s1_cell_reg;
    logic [IW-1:0]        s1_col_reg;

    logic                 left_blocked_reg;
    logic [SC-1:0]        left_score_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [SC-1:0]        out_score_reg;
    logic                 out_blocked_reg;

    logic                 load;
    logic                 commit;
    logic [RW-1:0]        above_word;
    logic [RW-1:0]        wr_word;

    logic                 blocked;
    logic [SC-1:0]        val_ext;
    logic [SC-1:0]        cand_up;
    logic [SC-1:0]        cand_left;
    logic                 have_up;
    logic                 have_left;
    logic [SC-1:0]        best;
    logic [SC-1:0]        score;

    // Handshake between the queue, the stage and the output register.
    assign commit = s1_valid_reg &&
                    (!s1_cell_reg.tag.last_cell || !out_valid_reg || !result_stall);
    assign load   = q_not_empty && (!s1_valid_reg || commit);

    always_comb
    begin
        status.load        = load;
        status.commit      = commit;
        status.last_commit = commit && s1_cell_reg.tag.last_cell;
    end

    // Row buffer: one score and one blocked flag per column.
    gmp_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_SIDE)
    ) u_row_buf (
        .clk     (clk),
        .wr_en   (commit),
        .wr_addr (s1_col_reg),
        .wr_data (wr_word),
        .rd_en   (load),
        .rd_addr (q_col),
        .rd_data (above_word)
    );

    // Score: best open neighbor minus its cost plus the value; zero if blocked.
    always_comb
    begin
        blocked   = (s1_cell_reg.value == gmp_pkg::BLOCKED_VALUE);
        val_ext   = SC'(s1_cell_reg.value);
        cand_up   = above_word[SC-1:0] - SC'(s1_cell_reg.cost_up);
        cand_left = left_score_reg - SC'(s1_cell_reg.cost_left);
        have_up   = !s1_cell_reg.tag.first_row && !above_word[SC];
        have_left = !s1_cell_reg.tag.first_col && !left_blocked_reg;
        if (have_up && have_left)
        begin
            best = ($signed(cand_left) > $signed(cand_up)) ? cand_left : cand_up;
        end
        else if (have_left)
        begin
            best = cand_left;
        end
        else
        begin
            best = cand_up;
        end
        if (blocked)
        begin
            score = '0;
        end
        else if (have_up || have_left)
        begin
            score = best + val_ext;
        end
        else
        begin
            score = val_ext;
        end
        wr_word = {blocked, score};
    end

    // Output register: a result beat waits here until it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (status.last_commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            left_blocked_reg <= 1'b0;
            left_score_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                left_blocked_reg <= blocked;
                left_score_reg   <= score;
            end
        end
    end

    // Stage and result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_cell_reg <= q_cell;
            s1_col_reg  <= q_col;
        end
        if (status.last_commit)
        begin
            out_score_reg   <= score;
            out_blocked_reg <= blocked;
        end
    end

    assign result_valid = out_valid_reg;
    assign best_score   = $signed(out_score_reg);
    assign end_blocked  = out_blocked_reg;

endmodule

`default_nettype wire

// ----- rtl/grid_max_path_dp_unit.sv -----
// ----------------------------------------------------------------------------
// grid_max_path_dp_unit: maximum-weight monotone path score over a grid
// Scores raster-ordered grid cells against one row buffer and reports the
// score of the final cell of each grid.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Payload
//  --------  ---------  ---------------------------  --------------------------
//  cell      in         cell_valid / cell_stall      cell_value, cost_from_above,
//                                                    cost_from_left
//  result    out        result_valid / result_stall  best_score, end_blocked
//  config    in         APB (psel, penable, ...)     grid_side at address 0
//
//  One cell is taken per clock while the queue has room; the loop through the
//  left score (subtract, compare, add) sets that rate. result_valid rises once
//  the final cell has passed the queue and the row-buffer read stage, and the
//  output register then holds the beat.
//  Reset clears the position counters and all valid flags; no clearing pass.
//  A stalled result holds back only the final cell of the next grid; the
//  two-entry queue then fills and cell_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_max_path_dp_unit #(
    parameter int unsigned MAX_SIDE = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Cell channel.
    input  wire logic                                cell_valid,
    output logic                                     cell_stall,
    input  wire logic signed [gmp_pkg::VAL_W-1:0]    cell_value,
    input  wire logic signed [gmp_pkg::VAL_W-1:0]    cost_from_above,
    input  wire logic signed [gmp_pkg::VAL_W-1:0]    cost_from_left,
    // Result channel.
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic signed [gmp_pkg::SCORE_W-1:0]       best_score,
    output logic                                     end_blocked,
    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [gmp_pkg::APB_AW-1:0]          paddr,
    input  wire logic [gmp_pkg::APB_DW-1:0]          pwdata,
    output logic [gmp_pkg::APB_DW-1:0]               prdata,
    output logic                                     pready
);

    localparam int unsigned IW = $clog2(MAX_SIDE);
    localparam int unsigned SW = $clog2(MAX_SIDE + 1);
    localparam int unsigned CELL_W = $bits(gmp_pkg::cell_t);
    localparam int unsigned QW = CELL_W + IW;

    logic [gmp_pkg::SIDE_W-1:0] grid_side_reg;
    logic [gmp_pkg::SIDE_W-1:0] grid_side_next;
    logic                       side_write;
    logic                       reg_sel;
    logic [31:0]                side_wide;
    logic [31:0]                side_clamped;
    logic [SW-1:0]              side;

    logic                       push;
    gmp_pkg::cell_t             front_cell;
    logic [IW-1:0]              front_col;
    logic [QW-1:0]              head_data;
    logic                       q_not_empty;
    logic                       q_full;
    gmp_pkg::cell_t             head_cell;
    logic [IW-1:0]              head_col;
    gmp_pkg::back_status_t      back_status;

    // Configuration register access.
    assign pready     = 1'b1;
    assign reg_sel    = (paddr[gmp_pkg::APB_AW-1:2] == 1'(gmp_pkg::REG_GRID_SIDE));
    assign side_write = psel && penable && pwrite && pready && reg_sel;

    always_comb
    begin
        grid_side_next = side_write ? pwdata[gmp_pkg::SIDE_W-1:0] : grid_side_reg;
        prdata         = reg_sel ? gmp_pkg::APB_DW'(grid_side_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg <= gmp_pkg::SIDE_W'(1);
        end
        else
        begin
            grid_side_reg <= grid_side_next;
        end
    end

    // Side in use: zero acts as one, anything above MAX_SIDE as MAX_SIDE.
    always_comb
    begin
        side_wide = 32'(grid_side_reg);
        if (side_wide == 32'd0)
        begin
            side_clamped = 32'd1;
        end
        else if (side_wide > 32'(MAX_SIDE))
        begin
            side_clamped = 32'(MAX_SIDE);
        end
        else
        begin
            side_clamped = side_wide;
        end
        side = side_clamped[SW-1:0];
    end

    // Front: intake and classification.
    gmp_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .restart         (side_write),
        .side            (side),
        .cell_valid      (cell_valid),
        .cell_value      (cell_value),
        .cost_from_above (cost_from_above),
        .cost_from_left  (cost_from_left),
        .q_full          (q_full),
        .push            (push),
        .cell_beat       (front_cell),
        .col             (front_col)
    );

    assign cell_stall = q_full;

    // Queue between front and back.
    gmp_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({front_col, front_cell}),
        .pop       (back_status.load),
        .head_data (head_data),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    assign head_cell = head_data[CELL_W-1:0];
    assign head_col  = head_data[QW-1:CELL_W];

    // Back: scoring datapath and result register.
    gmp_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_cell       (head_cell),
        .q_col        (head_col),
        .status       (back_status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .best_score   (best_score),
        .end_blocked  (end_blocked)
    );

    // The back never takes a beat from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.load |-> q_not_empty)
        else $error("back loaded from an empty queue");

    // Finishing the last cell of a grid always presents a result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.last_commit |=> result_valid)
        else $error("final cell retired without a result beat");

    // The front never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("front pushed into a full queue");

endmodule

`default_nettype wire
